@@ sv/lprl_pkg.sv @@
package lprl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int COUNT_W     = 7;
    localparam int INDEX_W     = 6;
    localparam int ADDR_W      = 32;
    localparam int INTF_W      = 4;

    // Slave tdata: entry_index, entry_prefix, entry_mask, entry_interface,
    // lookup_address, padded to whole bytes.
    localparam int S_FIELDS_W  = INDEX_W + 3 * ADDR_W + INTF_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Master tdata: out_interface, matched_index, padded to whole bytes.
    localparam int M_FIELDS_W  = INTF_W + INDEX_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } lprl_state_t;

    typedef struct packed {
        logic [INTF_W-1:0] port;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] prefix;
    } route_entry_t;

    typedef struct packed {
        logic in_ready;
        logic start;
        logic rd_en;
        logic out_load;
    } lprl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic out_free;
    } lprl_status_t;

endpackage

@@ sv/lprl_ctrl.sv @@
module lprl_ctrl
    import lprl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    input  lprl_status_t status,
    output lprl_cmd_t    cmd
);

    lprl_state_t state_reg;
    lprl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser == REQ_LOOKUP)) begin
                    state_next = status.count_zero ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.start    = s_tvalid && (s_tuser == REQ_LOOKUP);
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            ST_RESULT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // A lookup only starts from the idle state and always passes the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start && status.count_zero |=> state_reg == ST_RESULT)
        else $error("empty-table lookup did not go straight to result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |=> state_reg == ST_RESULT)
        else $error("drain did not hand over to result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("result load did not return to idle");

endmodule

@@ sv/lprl_datapath.sv @@
module lprl_datapath
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  s_tvalid,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    input  lprl_cmd_t             cmd,
    output lprl_status_t          status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int WX_W  = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    // Input field unpacking.
    logic [INDEX_W-1:0] in_index;
    logic [ADDR_W-1:0]  in_prefix;
    logic [ADDR_W-1:0]  in_mask;
    logic [INTF_W-1:0]  in_port;
    logic [ADDR_W-1:0]  in_address;

    assign in_index   = s_tdata[INDEX_W-1:0];
    assign in_prefix  = s_tdata[INDEX_W +: ADDR_W];
    assign in_mask    = s_tdata[INDEX_W + ADDR_W +: ADDR_W];
    assign in_port    = s_tdata[INDEX_W + 2 * ADDR_W +: INTF_W];
    assign in_address = s_tdata[INDEX_W + 2 * ADDR_W + INTF_W +: ADDR_W];

    logic [COUNT_W-1:0] route_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_count_reg <= '0;
        end else if (cfg_valid) begin
            route_count_reg <= cfg_data;
        end
    end

    // Route table memory: one write port, one registered read port.
    route_entry_t       table_mem [TABLE_DEPTH];
    route_entry_t       rd_data_reg;
    logic               wr_en;
    logic [WX_W-1:0]    wr_index_ext;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    route_entry_t       wr_entry;

    assign wr_index_ext = WX_W'(in_index);
    assign wr_addr      = wr_index_ext[IDX_W-1:0];
    assign wr_en        = s_tvalid && cmd.in_ready && (s_tuser == REQ_WRITE)
                          && (32'(in_index) < 32'(TABLE_DEPTH));
    assign wr_entry     = '{port: in_port, mask: in_mask, prefix: in_prefix};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Scan control.
    logic [CMP_W-1:0]  count_ext;
    logic [CNT_W-1:0]  limit_next;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              dv_reg;
    logic [IDX_W-1:0]  didx_reg;

    assign count_ext  = CMP_W'(route_count_reg);
    assign limit_next = (count_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(count_ext);
    assign rd_addr    = cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
        end else begin
            dv_reg <= cmd.rd_en;
            if (cmd.start) begin
                limit_reg <= limit_next;
                cnt_reg   <= '0;
            end else if (cmd.rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            addr_reg <= in_address;
        end
        if (cmd.rd_en) begin
            didx_reg <= rd_addr;
        end
    end

    // Best-match tracking.
    logic              best_found_reg;
    logic [ADDR_W-1:0] best_mask_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [INTF_W-1:0] best_port_reg;
    logic              hit;
    logic              take;

    assign hit  = (rd_data_reg.mask & addr_reg) == rd_data_reg.prefix;
    assign take = dv_reg && hit && (!best_found_reg || (rd_data_reg.mask > best_mask_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (cmd.start) begin
            best_found_reg <= 1'b0;
        end else if (take) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_mask_reg <= rd_data_reg.mask;
            best_idx_reg  <= didx_reg;
            best_port_reg <= rd_data_reg.port;
        end
    end

    // Output register.
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic                 found_out_reg;
    logic [INTF_W-1:0]    port_out_reg;
    logic [INDEX_W-1:0]   index_out_reg;
    logic [WX_W-1:0]      best_idx_ext;

    assign best_idx_ext  = WX_W'(best_idx_reg);
    assign m_tvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            found_out_reg <= best_found_reg;
            port_out_reg  <= best_found_reg ? best_port_reg : '0;
            index_out_reg <= best_found_reg ? best_idx_ext[INDEX_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_out_reg;
    assign m_tdata  = M_TDATA_W'({index_out_reg, port_out_reg});

    assign status.count_zero = (route_count_reg == '0);
    assign status.last_issue = (cnt_reg == (limit_reg - 1'b1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (cnt_reg < limit_reg))
        else $error("table read beyond scan limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        best_found_reg |-> (CNT_W'(best_idx_reg) < limit_reg))
        else $error("best entry outside scanned range");

endmodule

@@ sv/longest_prefix_route_lookup_top.sv @@
// Longest-prefix route lookup over a linear table of prefix/mask/interface entries.
// Requests arrive on the s_ stream. A write request (s_tuser = 0) stores one table
// entry in the cycle it is accepted and produces no result. A lookup request
// (s_tuser = 1) scans entries 0 .. route_count-1 and returns one result on the m_
// stream: found flag in m_tuser, interface and matched index in m_tdata. The best
// entry is the matching one with the greatest mask, the lowest index on a tie.
// route_count must be written through the cfg_ channel while no lookup is in flight;
// the block does not enforce this. A lookup steps through the scan, drain and result
// states before m_tvalid rises (from idle straight to result when route_count is 0;
// route_count is limited to TABLE_DEPTH entries), and the next request is taken back
// in idle. The scan does one table read per cycle through the single read port.
// Writes are taken one per cycle while idle. The table is not cleared by reset; only
// entries written since reset may be scanned. Reset (aresetn low, synchronous) clears
// route_count and all control. A finished result sits in an output register; if the
// receiver stalls, the block still accepts writes and starts the next lookup, which
// then waits in its result state until the output register is free.
module longest_prefix_route_lookup_top
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: route_count.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index[5:0], entry_prefix[37:6], entry_mask[69:38],
    // entry_interface[73:70], lookup_address[105:74], zero pad to 112 bits
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                  s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_interface[3:0], matched_index[9:4], zero pad to 16 bits
    output logic [M_TDATA_W-1:0]  m_tdata,
    // route_found[0]
    output logic                  m_tuser
);

    lprl_cmd_t    cmd;
    lprl_status_t status;

    // The count register is always writable; the user ensures writes only come while idle.
    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    lprl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    lprl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import lprl_pkg::*;

    // Bit positions of the request fields inside s_tdata, lowest field first.
    localparam int PREFIX_LSB = INDEX_W;
    localparam int MASK_LSB   = PREFIX_LSB + ADDR_W;
    localparam int INTF_LSB   = MASK_LSB + ADDR_W;
    localparam int ADDR_LSB   = INTF_LSB + INTF_W;

    // A lookup scans no more entries than the table depth, so this many cycles
    // covers any lookup still in flight.
    localparam int DRAIN_CYCLES = TABLE_DEPTH_DEF + 8;

    // Worst case is well under this: every request waits out a sender gap, a
    // full scan and a receiver stall, plus the long hold-off and the pauses
    // around each route_count write.
    localparam int CYCLE_LIMIT  = 400000;

    // One lookup answer as it appears on the result stream.
    typedef struct packed {
        logic              found;
        logic [INTF_W-1:0] port;
        logic [INDEX_W-1:0] index;
    } route_verdict_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Our own copy of the routing table and of route_count. The table is
    // updated when a write request is accepted, and each lookup request is
    // answered from it at the moment it is accepted.
    route_entry_t         route_table [TABLE_DEPTH_DEF];
    bit                   route_written [TABLE_DEPTH_DEF];
    logic [COUNT_W-1:0]   scan_count;

    // Answers still owed by the block, oldest first.
    route_verdict_t       pending_verdicts [$];

    int                   error_count = 0;
    int                   cycle_count = 0;
    // Set by the stimulus to make the receiver hold off for that many cycles.
    int                   hold_cycles = 0;
    // When set, neither side inserts idle cycles any more.
    bit                   calm = 1'b0;

    longest_prefix_route_lookup_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_verdicts.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Number of entries a lookup scans: route_count, capped at the depth.
    function automatic int scan_limit();
        return (scan_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(scan_count);
    endfunction

    // Longest-prefix choice: the matching entry with the numerically greatest
    // mask wins, and the strict compare keeps the lowest index on a tie.
    // Entry 0 competes like every other entry.
    function automatic route_verdict_t expected_verdict(input logic [ADDR_W-1:0] addr);
        route_verdict_t v;
        v = '0;
        for (int i = 0; i < scan_limit(); i++) begin
            if ((route_table[i].mask & addr) == route_table[i].prefix &&
                (!v.found || route_table[i].mask > route_table[v.index].mask)) begin
                v.found = 1'b1;
                v.port  = route_table[i].port;
                v.index = INDEX_W'(i);
            end
        end
        return v;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input logic [INDEX_W-1:0] slot,
        input logic [ADDR_W-1:0]  prefix,
        input logic [ADDR_W-1:0]  mask,
        input logic [INTF_W-1:0]  port,
        input logic [ADDR_W-1:0]  addr
    );
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[0 +: INDEX_W]         = slot;
        d[PREFIX_LSB +: ADDR_W] = prefix;
        d[MASK_LSB +: ADDR_W]   = mask;
        d[INTF_LSB +: INTF_W]   = port;
        d[ADDR_LSB +: ADDR_W]   = addr;
        return d;
    endfunction

    // Mostly well-formed routes: a contiguous netmask and a prefix aligned to
    // it, often carved out of an existing route so that routes nest, and now
    // and then an exact copy of one so that ties occur. The rest is noise with
    // an arbitrary mask and prefix, which usually can never match.
    function automatic route_entry_t make_route();
        route_entry_t r;
        int plen;
        int j;
        logic [ADDR_W-1:0] base;
        plen = $urandom_range(0, ADDR_W);
        j    = $urandom_range(0, TABLE_DEPTH_DEF - 1);
        base = $urandom;
        if (route_written[j] && $urandom_range(0, 1) == 1)
            base = route_table[j].prefix | (base & ~route_table[j].mask);
        r.port = INTF_W'($urandom_range(0, 15));
        if ($urandom_range(0, 7) == 0) begin
            r.mask   = $urandom;
            r.prefix = $urandom;
        end else if (route_written[j] && $urandom_range(0, 7) == 0) begin
            r.mask   = route_table[j].mask;
            r.prefix = route_table[j].prefix;
        end else begin
            r.mask   = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
            r.prefix = base & r.mask;
        end
        return r;
    endfunction

    // Most addresses fall inside some route within the scanned range, with
    // random host bits; the rest are fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        int j;
        if (scan_limit() == 0 || $urandom_range(0, 4) == 0)
            return $urandom;
        j = $urandom_range(0, scan_limit() - 1);
        return route_table[j].prefix | ($urandom & ~route_table[j].mask);
    endfunction

    // Called once a request has been accepted: a write updates the table, a
    // lookup queues the answer it must produce.
    task automatic predict_request(input logic kind, input logic [S_TDATA_W-1:0] data);
        logic [INDEX_W-1:0] slot;
        slot = data[0 +: INDEX_W];
        if (kind == REQ_WRITE) begin
            route_table[slot].prefix = data[PREFIX_LSB +: ADDR_W];
            route_table[slot].mask   = data[MASK_LSB +: ADDR_W];
            route_table[slot].port   = data[INTF_LSB +: INTF_W];
            route_written[slot]      = 1'b1;
        end else begin
            pending_verdicts.push_back(expected_verdict(data[ADDR_LSB +: ADDR_W]));
        end
    endtask

    // Offers one request and returns at the edge where it is accepted. tvalid
    // is left high so that the next request can follow without a gap; a gap,
    // when one is drawn, lowers it at the start of the next call.
    task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] data);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(kind, data);
    endtask

    // The fields a request does not use carry random values, since the block
    // must ignore them.
    task automatic write_route(
        input logic [INDEX_W-1:0] slot,
        input logic [ADDR_W-1:0]  prefix,
        input logic [ADDR_W-1:0]  mask,
        input logic [INTF_W-1:0]  port
    );
        send_request(REQ_WRITE, pack_request(slot, prefix, mask, port, $urandom));
    endtask

    task automatic look_up(input logic [ADDR_W-1:0] addr);
        send_request(REQ_LOOKUP, pack_request(INDEX_W'($urandom), $urandom, $urandom,
                                              INTF_W'($urandom), addr));
    endtask

    // route_count may change only while the block is idle: every answer has
    // come back and any scan has had time to finish.
    task automatic set_route_count(input logic [COUNT_W-1:0] count);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        scan_count  = count;
    endtask

    // Right after reset route_count is zero, so nothing is scanned and every
    // lookup misses, whatever the address.
    task automatic test_empty_table();
        look_up('0);
        look_up('1);
    endtask

    // Hand-built routes: a default route in entry 0, nested prefixes, two equal
    // masks that both match, a host route at the all-ones extremes, and a
    // prefix with bits outside its mask, which can never match.
    task automatic test_directed_routes();
        write_route(6'd0, 32'h0000_0000, 32'h0000_0000, 4'd5);
        write_route(6'd1, 32'h0A00_0000, 32'hFF00_0000, 4'd1);
        write_route(6'd2, 32'h0A01_0000, 32'hFFFF_0000, 4'd2);
        write_route(6'd3, 32'h0A01_0000, 32'hFFFF_0000, 4'd3);
        write_route(6'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        write_route(6'd5, 32'h0B00_0001, 32'hFF00_0000, 4'd7);
        write_route(6'd63, 32'hC0A8_0000, 32'hFFFF_0000, 4'd0);
        set_route_count(7'd6);
        look_up(32'h0A01_0203);
        look_up(32'h0A02_0304);
        look_up(32'h0B00_0001);
        look_up(32'hFFFF_FFFF);
        look_up(32'h0000_0000);
        // With one entry in use, only the default route in entry 0 is seen.
        set_route_count(7'd1);
        look_up(32'h0A01_0203);
        // Entry 0 no longer covers everything, so this address misses.
        write_route(6'd0, 32'h0100_0000, 32'hFF00_0000, 4'd6);
        look_up(32'h0200_0000);
        look_up(32'h01AB_CDEF);
    endtask

    // Writes every entry not yet written, so that any route_count is safe.
    task automatic test_fill_table();
        route_entry_t r;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            if (!route_written[i]) begin
                r = make_route();
                write_route(INDEX_W'(i), r.prefix, r.mask, r.port);
            end
        end
    endtask

    // Lookups mixed with table rewrites; about one request in four is a write.
    task automatic test_random_traffic(input int n_items, input logic [COUNT_W-1:0] count);
        route_entry_t r;
        set_route_count(count);
        repeat (n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                r = make_route();
                write_route(INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                            r.prefix, r.mask, r.port);
            end else begin
                look_up(pick_address());
            end
        end
    endtask

    // The receiver stops for a long stretch while lookups keep coming, so the
    // output register fills, the next lookup parks in its result state and
    // the request stream stalls.
    task automatic test_back_pressure();
        set_route_count(COUNT_W'(TABLE_DEPTH_DEF));
        hold_cycles = 300;
        repeat (24) look_up(pick_address());
    endtask

    // Result receiver: random stall bursts, plus the long hold-off on demand.
    initial begin : result_sink
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Every answer taken from the block is compared with the oldest one owed.
    always @(posedge aclk) begin : result_check
        route_verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("answer with no lookup pending: found=%0b",
                                          m_tuser));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch($sformatf("route_found %0b, want %0b",
                                              m_tuser, want.found));
                if (m_tdata[0 +: INTF_W] !== want.port)
                    report_mismatch($sformatf("out_interface %0d, want %0d",
                                              m_tdata[0 +: INTF_W], want.port));
                if (m_tdata[INTF_W +: INDEX_W] !== want.index)
                    report_mismatch($sformatf("matched_index %0d, want %0d",
                                              m_tdata[INTF_W +: INDEX_W], want.index));
            end
        end
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= REQ_WRITE;
        s_tdata   <= '0;
        scan_count = '0;
        foreach (route_written[i]) route_written[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_directed_routes();
        test_fill_table();
        // route_count at the depth, at its all-ones maximum, just above the
        // depth, at one and at zero.
        test_random_traffic(150, COUNT_W'(TABLE_DEPTH_DEF));
        test_random_traffic(150, '1);
        test_random_traffic(100, COUNT_W'(TABLE_DEPTH_DEF + 1));
        test_random_traffic(80, 7'd1);
        test_random_traffic(40, 7'd0);
        repeat (4) test_random_traffic(100,
                                       COUNT_W'($urandom_range(2, TABLE_DEPTH_DEF - 1)));
        test_back_pressure();
        // Closing stretch at full rate with no idling on either side.
        calm = 1'b1;
        test_random_traffic(120, COUNT_W'(TABLE_DEPTH_DEF));

        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
